@@ rtl/core/tlzw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlzw_pkg
// Shared types and fixed constants of the TIFF LZW decoder core.
// ----------------------------------------------------------------------------
package tlzw_pkg;

  // operation carried by one input transaction
  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_PULL  = 2'd1,
    OP_END   = 2'd2,
    OP_STRIP = 2'd3
  } tlzw_op_e;

  // decoder status as reported on the result channel
  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_OK      = 2'd1,
    ST_FAIL    = 2'd2,
    ST_REFUSED = 2'd3
  } tlzw_status_e;

  // one queued input transaction
  typedef struct packed {
    tlzw_op_e    op;
    logic [7:0]  data;
  } tlzw_item_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic        valid;
    tlzw_item_t  item;
  } tlzw_head_t;

  localparam int unsigned CODE_CLEAR = 256;
  localparam int unsigned CODE_END   = 257;
  localparam int unsigned FIRST_FREE = 258;
  localparam int unsigned MIN_WIDTH  = 9;
  localparam int unsigned BUF_W      = 24;
  localparam int unsigned HELD_W     = 5;
  localparam logic [31:0] SIZE_SAT   = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/tlzw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlzw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tlzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tlzw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlzw_front
// Accepts input transactions, classifies the operation and queues them in a
// two entry queue for the back end.
// ----------------------------------------------------------------------------
module tlzw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          data_byte_i,
  output tlzw_pkg::tlzw_head_t head_o,
  input  logic                pop_i
);
  import tlzw_pkg::*;

  tlzw_item_t  mem_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;
  tlzw_item_t  new_item;

  // classify incoming transaction
  assign new_item.op   = tlzw_op_e'(op_i);
  assign new_item.data = data_byte_i;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = mem_q[rptr_q];

  // queue pointers
  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= new_item;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 && !push) |=> count_q == 2'd0) else $error("queue underflow");
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop_i) |=> count_q == 2'd2) else $error("queue lost an entry");

endmodule

@@ rtl/core/tlzw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlzw_back
// Executes queued transactions: bit unpacking, code decoding, prefix chain
// walk into the string buffer, dictionary update, chunked output and the
// result register.
// ----------------------------------------------------------------------------
module tlzw_back #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned CHUNK_BYTES   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlzw_pkg::tlzw_head_t head_i,
  output logic                 pop_o,
  input  logic [31:0]          exp_size_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [63:0]          out_bytes_o,
  output logic [3:0]           out_count_o,
  output logic                 more_pending_o
);
  import tlzw_pkg::*;

  localparam int unsigned TW    = MAX_CODE_BITS;
  localparam int unsigned NFW   = TW + 1;
  localparam int unsigned LW    = TW + 1;
  localparam int unsigned CWW   = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned DW    = TW + 8 + LW;
  localparam int unsigned DEPTH = 1 << TW;

  localparam logic [TW-1:0]  C_CLEAR = TW'(CODE_CLEAR);
  localparam logic [TW-1:0]  C_END   = TW'(CODE_END);
  localparam logic [NFW-1:0] C_FIRST = NFW'(FIRST_FREE);
  localparam logic [CWW-1:0] W_MIN   = CWW'(MIN_WIDTH);
  localparam logic [CWW-1:0] W_MAX   = CWW'(MAX_CODE_BITS);
  localparam logic [NFW-1:0] TBL_SZ  = NFW'(DEPTH);
  localparam logic [3:0]     CHUNK   = 4'(CHUNK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_CODE, S_WALK, S_FIN, S_PULL, S_OUT
  } state_e;

  state_e             state_q, state_d;
  tlzw_status_e       status_q, status_d;
  logic [BUF_W-1:0]   buf_q, buf_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic [CWW-1:0]     width_q, width_d;
  logic [NFW-1:0]     nf_q, nf_d;
  logic [TW-1:0]      prev_q, prev_d;
  logic               prev_valid_q, prev_valid_d;
  logic [LW-1:0]      prev_len_q, prev_len_d;
  logic [31:0]        total_q, total_d;
  logic [LW-1:0]      pend_q, pend_d;
  logic [LW-1:0]      rp_q, rp_d;
  logic [TW-1:0]      code_q, code_d;
  logic               kwk_q, kwk_d;
  logic [TW-1:0]      cur_q, cur_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic               first_q, first_d;
  logic [LW-1:0]      len_q, len_d;
  logic [7:0]         fch_q, fch_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               issue_q, issue_d;
  tlzw_status_e       res_status_q, res_status_d;
  logic [63:0]        res_bytes_q, res_bytes_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, out_status_d;
  logic [63:0]        out_bytes_q, out_bytes_d;
  logic [3:0]         out_count_q, out_count_d;
  logic               out_more_q, out_more_d;

  // memory ports
  logic               dict_we;
  logic [TW-1:0]      dict_raddr;
  logic [DW-1:0]      dict_wdata, dict_rdata;
  logic               sb_we;
  logic [TW-1:0]      sb_waddr;
  logic [7:0]         sb_wdata, sb_rdata;

  // bit unpacking path
  logic [BUF_W-1:0]   nbuf, shifted, cmask, rmask;
  logic [HELD_W-1:0]  nheld, wid_h, sh;
  logic               have_code;
  logic [TW-1:0]      new_code;

  // walk and update path
  logic [TW-1:0]      rd_pre;
  logic [7:0]         rd_suf, node_suf;
  logic [LW-1:0]      rd_len, node_len, widx, len_eff;
  logic               lit;
  logic [NFW-1:0]     nf_inc, grow_at;
  logic [31:0]        diff;
  logic [32:0]        sum33;
  logic               can_issue;

  tlzw_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (nf_q[TW-1:0]),
    .wdata_i (dict_wdata),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  tlzw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_sbuf (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (sb_waddr),
    .wdata_i (sb_wdata),
    .raddr_i (rp_q[TW-1:0]),
    .rdata_o (sb_rdata)
  );

  // unpack the next code from the bit buffer
  assign nbuf      = {buf_q[BUF_W-9:0], head_i.item.data};
  assign nheld     = held_q + HELD_W'(8);
  assign wid_h     = HELD_W'(width_q);
  assign have_code = (nheld >= wid_h);
  assign sh        = nheld - wid_h;
  assign shifted   = nbuf >> sh;
  assign cmask     = (BUF_W'(1) << width_q) - BUF_W'(1);
  assign rmask     = (BUF_W'(1) << sh) - BUF_W'(1);
  assign new_code  = TW'(shifted & cmask);

  // dictionary node under the walk pointer, literals are implicit
  assign rd_pre   = dict_rdata[DW-1 -: TW];
  assign rd_suf   = dict_rdata[LW +: 8];
  assign rd_len   = dict_rdata[LW-1:0];
  assign lit      = (cur_q[TW-1:8] == '0);
  assign node_suf = lit ? cur_q[7:0] : rd_suf;
  assign node_len = lit ? LW'(1) : rd_len;
  assign widx     = first_q ? node_len : idx_q;

  // dictionary update and byte accounting
  assign len_eff    = kwk_q ? len_q + LW'(1) : len_q;
  assign nf_inc     = nf_q + NFW'(1);
  assign grow_at    = (NFW'(1) << width_q) - NFW'(1);
  assign diff       = exp_size_i - total_q;
  assign sum33      = {1'b0, total_q} + 33'(len_eff);
  assign dict_wdata = {prev_q, fch_q, prev_len_q + LW'(1)};

  // chunk read
  assign can_issue = ((cnt_q + 4'(issue_q)) < CHUNK) && (rp_q < pend_q);

  // next state
  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    buf_d        = buf_q;
    held_d       = held_q;
    width_d      = width_q;
    nf_d         = nf_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    prev_len_d   = prev_len_q;
    total_d      = total_q;
    pend_d       = pend_q;
    rp_d         = rp_q;
    code_d       = code_q;
    kwk_d        = kwk_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    first_d      = first_q;
    len_d        = len_q;
    fch_d        = fch_q;
    cnt_d        = cnt_q;
    issue_d      = issue_q;
    res_status_d = res_status_q;
    res_bytes_d  = res_bytes_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_bytes_d  = out_bytes_q;
    out_count_d  = out_count_q;
    out_more_d   = out_more_q;
    pop_o        = 1'b0;
    dict_we      = 1'b0;
    dict_raddr   = cur_q;
    sb_we        = 1'b0;
    sb_waddr     = TW'(widx - LW'(1));
    sb_wdata     = node_suf;

    unique case (state_q)
      // take the next transaction from the queue
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o        = 1'b1;
          res_bytes_d  = '0;
          cnt_d        = '0;
          issue_d      = 1'b0;
          res_status_d = status_q;
          state_d      = S_OUT;
          unique case (head_i.item.op)
            OP_FEED: begin
              if (status_q == ST_RUN && pend_q != '0) begin
                res_status_d = ST_REFUSED;
              end else if (status_q == ST_RUN) begin
                if (have_code) begin
                  buf_d   = nbuf & rmask;
                  held_d  = sh;
                  code_d  = new_code;
                  state_d = S_CODE;
                end else begin
                  buf_d  = nbuf;
                  held_d = nheld;
                end
              end
            end
            OP_PULL: begin
              state_d = S_PULL;
            end
            OP_END: begin
              if (status_q == ST_RUN) begin
                if (exp_size_i != '0 && total_q == exp_size_i) begin
                  status_d     = ST_OK;
                  res_status_d = ST_OK;
                end else begin
                  status_d     = ST_FAIL;
                  res_status_d = ST_FAIL;
                  pend_d       = '0;
                  rp_d         = '0;
                end
              end
            end
            OP_STRIP: begin
              status_d     = ST_RUN;
              res_status_d = ST_RUN;
              buf_d        = '0;
              held_d       = '0;
              width_d      = W_MIN;
              nf_d         = C_FIRST;
              prev_d       = '0;
              prev_valid_d = 1'b0;
              total_d      = '0;
              pend_d       = '0;
              rp_d         = '0;
            end
            default: ;
          endcase
        end
      end

      // classify the unpacked code
      S_CODE: begin
        state_d = S_OUT;
        if (code_q == C_END) begin
          status_d     = ST_OK;
          res_status_d = ST_OK;
        end else if (code_q == C_CLEAR) begin
          width_d      = W_MIN;
          nf_d         = C_FIRST;
          prev_valid_d = 1'b0;
        end else if (NFW'(code_q) > nf_q) begin
          status_d     = ST_FAIL;
          res_status_d = ST_FAIL;
          pend_d       = '0;
          rp_d         = '0;
        end else if (NFW'(code_q) < nf_q) begin
          kwk_d      = 1'b0;
          cur_d      = code_q;
          dict_raddr = code_q;
          first_d    = 1'b1;
          state_d    = S_WALK;
        end else if (!prev_valid_q) begin
          status_d     = ST_FAIL;
          res_status_d = ST_FAIL;
          pend_d       = '0;
          rp_d         = '0;
        end else begin
          kwk_d      = 1'b1;
          cur_d      = prev_q;
          dict_raddr = prev_q;
          first_d    = 1'b1;
          state_d    = S_WALK;
        end
      end

      // one prefix chain node per cycle, string written back to front
      S_WALK: begin
        sb_we   = 1'b1;
        first_d = 1'b0;
        if (first_q) begin
          len_d = node_len;
        end
        if (widx <= LW'(1)) begin
          fch_d   = node_suf;
          state_d = S_FIN;
        end else begin
          idx_d      = widx - LW'(1);
          cur_d      = rd_pre;
          dict_raddr = rd_pre;
        end
      end

      // repeat first byte for kwkwk, add entry, account bytes
      S_FIN: begin
        state_d = S_OUT;
        if (kwk_q) begin
          sb_we    = 1'b1;
          sb_waddr = len_q[TW-1:0];
          sb_wdata = fch_q;
        end
        if ((kwk_q || prev_valid_q) && nf_q < TBL_SZ) begin
          dict_we = 1'b1;
          nf_d    = nf_inc;
          if (width_q < W_MAX && nf_inc == grow_at) begin
            width_d = width_q + CWW'(1);
          end
        end
        prev_d       = code_q;
        prev_valid_d = 1'b1;
        prev_len_d   = len_eff;
        res_status_d = status_q;
        if (exp_size_i != '0 && 32'(len_eff) > diff) begin
          status_d     = ST_FAIL;
          res_status_d = ST_FAIL;
          pend_d       = '0;
          rp_d         = '0;
        end else begin
          if (exp_size_i == '0 && sum33[32]) begin
            total_d = SIZE_SAT;
          end else begin
            total_d = sum33[31:0];
          end
          pend_d = len_eff;
          rp_d   = '0;
        end
      end

      // stream up to one chunk out of the string buffer
      S_PULL: begin
        if (issue_q) begin
          res_bytes_d[{cnt_q[2:0], 3'b000} +: 8] = sb_rdata;
          cnt_d = cnt_q + 4'd1;
        end
        if (can_issue) begin
          rp_d    = rp_q + LW'(1);
          issue_d = 1'b1;
        end else begin
          issue_d = 1'b0;
          if (!issue_q) begin
            state_d = S_OUT;
            if (rp_q >= pend_q) begin
              pend_d = '0;
              rp_d   = '0;
            end
          end
        end
      end

      // hand the result to the output register
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_bytes_d  = res_bytes_q;
          out_count_d  = cnt_q;
          out_more_d   = (pend_q > rp_q);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      status_q     <= ST_RUN;
      buf_q        <= '0;
      held_q       <= '0;
      width_q      <= W_MIN;
      nf_q         <= C_FIRST;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      prev_len_q   <= '0;
      total_q      <= '0;
      pend_q       <= '0;
      rp_q         <= '0;
      code_q       <= '0;
      kwk_q        <= 1'b0;
      cur_q        <= '0;
      idx_q        <= '0;
      first_q      <= 1'b0;
      len_q        <= '0;
      fch_q        <= '0;
      cnt_q        <= '0;
      issue_q      <= 1'b0;
      res_status_q <= ST_RUN;
      res_bytes_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_bytes_q  <= '0;
      out_count_q  <= '0;
      out_more_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      status_q     <= status_d;
      buf_q        <= buf_d;
      held_q       <= held_d;
      width_q      <= width_d;
      nf_q         <= nf_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      prev_len_q   <= prev_len_d;
      total_q      <= total_d;
      pend_q       <= pend_d;
      rp_q         <= rp_d;
      code_q       <= code_d;
      kwk_q        <= kwk_d;
      cur_q        <= cur_d;
      idx_q        <= idx_d;
      first_q      <= first_d;
      len_q        <= len_d;
      fch_q        <= fch_d;
      cnt_q        <= cnt_d;
      issue_q      <= issue_d;
      res_status_q <= res_status_d;
      res_bytes_q  <= res_bytes_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_bytes_q  <= out_bytes_d;
      out_count_q  <= out_count_d;
      out_more_q   <= out_more_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_bytes_o    = out_bytes_q;
  assign out_count_o    = out_count_q;
  assign more_pending_o = out_more_q;

  a_held_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < HELD_W'(width_q)) else $error("bit buffer holds a whole code");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= pend_q) else $error("read pointer beyond pending length");
  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !first_q) |-> idx_q != '0) else $error("walk index underflow");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_bytes_q)))
    else $error("stalled result overwritten");

endmodule

@@ rtl/core/tiff_lzw_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiff_lzw_decoder_core
// TIFF LZW strip decoder: byte feed, chunked pull output, status reporting.
// ----------------------------------------------------------------------------
// Each transaction yields exactly one result. Transactions are queued two
// deep and executed one at a time. A fed byte that completes no code goes
// straight to the result; for one that completes a code, the code is
// classified, the prefix chain walk through the registered dictionary RAM
// writes the string one node per byte and the dictionary is updated. A pull
// reads the string buffer once per byte returned. End and new strip go
// straight to the result. No clearing pass is needed after reset: the literal
// entries are implied and every other entry is written before it is read.
module tiff_lzw_decoder_core #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned CHUNK_BYTES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  out_count_o,
  output logic        more_pending_o
);
  import tlzw_pkg::*;

  logic [31:0] exp_size_q;
  tlzw_head_t  head;
  logic        pop;

  // expected size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= '0;
    end else if (cfg_we_i) begin
      exp_size_q <= cfg_wdata_i;
    end
  end

  tlzw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  tlzw_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .CHUNK_BYTES   (CHUNK_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .exp_size_i     (exp_size_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_bytes_o    (out_bytes_o),
    .out_count_o    (out_count_o),
    .more_pending_o (more_pending_o)
  );

endmodule
